// ----- rtl/sacu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacu_pkg
// shared types, register codes and cost constants of the cache timing model
// ----------------------------------------------------------------------------
package sacu_pkg;

	localparam int ADDR_PORT_W = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 4;
	localparam int CNT_W       = 32;
	localparam int TOT_W       = 48;
	localparam int COST_W      = 16;
	localparam int WAY_OUT_W   = 3;

	localparam int DEF_MAX_SETS     = 256;
	localparam int DEF_MAX_WAYS     = 8;
	localparam int DEF_ADDRESS_BITS = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLK_LOG2    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_LOG2    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOC = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_USE_LRU     = 3'd5;

	// reset values
	localparam logic [3:0] RST_BLK_LOG2 = 4'd4;
	localparam logic [3:0] RST_SET_LOG2 = 4'd8;
	localparam logic [3:0] RST_WAYS     = 4'd4;

	localparam logic [3:0] OFF_MIN = 4'd2;
	localparam logic [3:0] OFF_MAX = 4'd10;

	localparam logic [COST_W-1:0] MEM_COST    = 16'd100;
	localparam logic [COST_W-1:0] ACCESS_COST = 16'd1;

	typedef struct packed {
		logic [3:0] blk_log2;
		logic [3:0] set_log2;
		logic [3:0] ways;
		logic       write_alloc;
		logic       write_back;
		logic       use_lru;
	} cfg_t;

	typedef struct packed {
		logic                 hit;
		logic                 alloc;
		logic                 wrote_back;
		logic [WAY_OUT_W-1:0] way;
		logic [COST_W-1:0]    cost;
	} outcome_t;

	// cost of one block transfer: words per block times memory cost
	function automatic logic [COST_W-1:0] blk_cost(input logic [3:0] off);
		return MEM_COST << (off - OFF_MIN);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sacu_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacu_row_mem
// one row per set: valid, dirty, age order and tags, with a row-valid flop
// ----------------------------------------------------------------------------
module sacu_row_mem #(
	parameter int MAX_WAYS = 8,
	parameter int SETS     = 256,
	parameter int SI_W     = 8,
	parameter int WAY_W    = 3,
	parameter int TAG_W    = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              flush,
	input  logic                              rd_en,
	input  logic [SI_W-1:0]                   rd_addr,
	input  logic                              wr_en,
	input  logic [SI_W-1:0]                   wr_addr,
	input  logic [MAX_WAYS-1:0]               wr_valid,
	input  logic [MAX_WAYS-1:0]               wr_dirty,
	input  logic [MAX_WAYS-1:0][WAY_W-1:0]    wr_order,
	input  logic [MAX_WAYS-1:0][TAG_W-1:0]    wr_tags,
	output logic [MAX_WAYS-1:0]               rd_valid,
	output logic [MAX_WAYS-1:0]               rd_dirty,
	output logic [MAX_WAYS-1:0][WAY_W-1:0]    rd_order,
	output logic [MAX_WAYS-1:0][TAG_W-1:0]    rd_tags
);
	logic [MAX_WAYS-1:0]            valid_mem [SETS];
	logic [MAX_WAYS-1:0]            dirty_mem [SETS];
	logic [MAX_WAYS-1:0][WAY_W-1:0] order_mem [SETS];
	logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem   [SETS];

	logic [SETS-1:0]                row_ok_q;
	logic                           ok_q;
	logic [MAX_WAYS-1:0]            valid_q;
	logic [MAX_WAYS-1:0]            dirty_q;
	logic [MAX_WAYS-1:0][WAY_W-1:0] order_q;
	logic [MAX_WAYS-1:0][WAY_W-1:0] id_order;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			id_order[i] = WAY_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			valid_mem[wr_addr] <= wr_valid;
			dirty_mem[wr_addr] <= wr_dirty;
			order_mem[wr_addr] <= wr_order;
			tag_mem[wr_addr]   <= wr_tags;
		end
		if (rd_en) begin
			valid_q <= valid_mem[rd_addr];
			dirty_q <= dirty_mem[rd_addr];
			order_q <= order_mem[rd_addr];
			rd_tags <= tag_mem[rd_addr];
		end
	end

	// a row never written since reset or flush reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			ok_q     <= 1'b0;
		end else begin
			if (flush) begin
				row_ok_q <= '0;
			end else if (wr_en) begin
				row_ok_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ok_q <= row_ok_q[rd_addr];
			end
		end
	end

	assign rd_valid = ok_q ? valid_q : '0;
	assign rd_dirty = ok_q ? dirty_q : '0;
	assign rd_order = ok_q ? order_q : id_order;

endmodule
`default_nettype wire

// ----- rtl/sacu_row_upd.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacu_row_upd
// hit / fill decision, cost, and the new row with its age order
// ----------------------------------------------------------------------------
module sacu_row_upd #(
	parameter int MAX_WAYS = 8,
	parameter int WAY_W    = 3,
	parameter int NW_W     = 4,
	parameter int TAG_W    = 30
) (
	input  logic                              hit_in,
	input  logic [WAY_W-1:0]                  hit_way,
	input  logic                              is_store,
	input  logic [TAG_W-1:0]                  tag,
	input  sacu_pkg::cfg_t                    cfg,
	input  logic [NW_W-1:0]                   nw,
	input  logic [sacu_pkg::COST_W-1:0]       blk,
	input  logic [MAX_WAYS-1:0]               old_valid,
	input  logic [MAX_WAYS-1:0]               old_dirty,
	input  logic [MAX_WAYS-1:0][WAY_W-1:0]    old_order,
	input  logic [MAX_WAYS-1:0][TAG_W-1:0]    old_tags,
	output logic [MAX_WAYS-1:0]               new_valid,
	output logic [MAX_WAYS-1:0]               new_dirty,
	output logic [MAX_WAYS-1:0][WAY_W-1:0]    new_order,
	output logic [MAX_WAYS-1:0][TAG_W-1:0]    new_tags,
	output sacu_pkg::outcome_t                outcome
);
	import sacu_pkg::*;

	typedef logic [MAX_WAYS-1:0][WAY_W-1:0] ord_t;

	// move a way to the tail of the first n positions
	function automatic ord_t move_tail(input ord_t o, input logic [NW_W-1:0] n,
	                                   input logic [WAY_W-1:0] w);
		ord_t r;
		ord_t nxt;
		logic seen;
		seen = 1'b0;
		nxt  = o >> WAY_W;
		for (int q = 0; q < MAX_WAYS; q++) begin
			if (!seen && (NW_W'(q) < n) && (o[q] == w)) begin
				seen = 1'b1;
			end
			if (seen && (NW_W'(q + 1) < n)) begin
				r[q] = nxt[q];
			end else if (seen && (NW_W'(q + 1) == n)) begin
				r[q] = w;
			end else begin
				r[q] = o[q];
			end
		end
		return r;
	endfunction

	logic [WAY_W-1:0]  victim;
	logic [WAY_W-1:0]  way;
	logic [COST_W-1:0] cost;
	logic              alloc;
	logic              wb;
	logic              touch;
	ord_t              order1;

	assign victim = old_order[0] & WAY_W'(MAX_WAYS - 1);

	always_comb begin
		new_valid = old_valid;
		new_dirty = old_dirty;
		new_tags  = old_tags;
		cost      = '0;
		alloc     = 1'b0;
		wb        = 1'b0;
		touch     = 1'b1;
		way       = '0;
		if (hit_in) begin
			cost = ACCESS_COST;
			way  = hit_way;
			if (is_store) begin
				if (cfg.write_back) begin
					new_dirty[hit_way] = 1'b1;
				end else begin
					cost = cost + MEM_COST;
				end
			end
		end else if (is_store && !cfg.write_alloc) begin
			// store miss straight to memory
			cost  = MEM_COST;
			touch = 1'b0;
		end else begin
			alloc = 1'b1;
			way   = victim;
			if (cfg.write_back) begin
				if (old_dirty[victim]) begin
					cost = cost + blk;
					wb   = 1'b1;
				end
				new_dirty[victim] = is_store;
			end
			cost              = cost + blk + ACCESS_COST;
			new_valid[victim] = 1'b1;
			new_tags[victim]  = tag;
		end
		order1    = alloc ? move_tail(old_order, nw, old_order[0]) : old_order;
		new_order = (touch && cfg.use_lru) ? move_tail(order1, nw, way) : order1;
	end

	assign outcome.hit        = hit_in;
	assign outcome.alloc      = alloc;
	assign outcome.wrote_back = wb;
	assign outcome.way        = WAY_OUT_W'(way);
	assign outcome.cost       = cost;

endmodule
`default_nettype wire

// ----- rtl/sacu_counters.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacu_counters
// saturating access, hit, miss and cycle totals
// ----------------------------------------------------------------------------
module sacu_counters (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  logic                       is_store,
	input  sacu_pkg::outcome_t         outcome,
	output logic [sacu_pkg::CNT_W-1:0] load_count,
	output logic [sacu_pkg::CNT_W-1:0] store_count,
	output logic [sacu_pkg::CNT_W-1:0] load_hit_count,
	output logic [sacu_pkg::CNT_W-1:0] load_miss_count,
	output logic [sacu_pkg::CNT_W-1:0] store_hit_count,
	output logic [sacu_pkg::CNT_W-1:0] store_miss_count,
	output logic [sacu_pkg::TOT_W-1:0] total_cycle_count
);
	import sacu_pkg::*;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

	logic [TOT_W:0] tot_sum;

	assign tot_sum = {1'b0, total_cycle_count} + (TOT_W + 1)'(outcome.cost);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count        <= '0;
			store_count       <= '0;
			load_hit_count    <= '0;
			load_miss_count   <= '0;
			store_hit_count   <= '0;
			store_miss_count  <= '0;
			total_cycle_count <= '0;
		end else if (upd) begin
			if (is_store) begin
				store_count <= sat_inc(store_count);
				if (outcome.hit) begin
					store_hit_count <= sat_inc(store_hit_count);
				end else begin
					store_miss_count <= sat_inc(store_miss_count);
				end
			end else begin
				load_count <= sat_inc(load_count);
				if (outcome.hit) begin
					load_hit_count <= sat_inc(load_hit_count);
				end else begin
					load_miss_count <= sat_inc(load_miss_count);
				end
			end
			// carry out means the total has passed its maximum
			total_cycle_count <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/set_assoc_cache_timing_model_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_timing_model_unit
// set-associative cache timing model with lru or fifo replacement
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in_valid  / in_ready  | req_type, address
//  out     | out_valid / out_ready | hit, allocated, wrote_back, way_used,
//          |                       | cycles_added, running totals
//
//  an access word is taken in the idle state; its result word is presented
//  after the set read, the tag compares and the row write-back, in that order;
//  the compares step through the ways one at a time on a single tag comparator,
//  from way 0 up to the ways in use, stopping at the first hit
//  in_ready is low from acceptance until the row write-back
//  a result waiting on out_ready holds the row write-back but not the input
//  side once it is idle; cfg_ready is always high
//  reset and any geometry register write empty the cache at once through
//  per-set row-valid flops, so there is no clearing pass
// ----------------------------------------------------------------------------
module set_assoc_cache_timing_model_unit #(
	parameter int MAX_SETS     = sacu_pkg::DEF_MAX_SETS,
	parameter int MAX_WAYS     = sacu_pkg::DEF_MAX_WAYS,
	parameter int ADDRESS_BITS = sacu_pkg::DEF_ADDRESS_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sacu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [sacu_pkg::ADDR_PORT_W-1:0] address,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic                             allocated,
	output logic                             wrote_back,
	output logic [sacu_pkg::WAY_OUT_W-1:0]   way_used,
	output logic [sacu_pkg::COST_W-1:0]      cycles_added,
	output logic [sacu_pkg::CNT_W-1:0]       load_count,
	output logic [sacu_pkg::CNT_W-1:0]       store_count,
	output logic [sacu_pkg::CNT_W-1:0]       load_hit_count,
	output logic [sacu_pkg::CNT_W-1:0]       load_miss_count,
	output logic [sacu_pkg::CNT_W-1:0]       store_hit_count,
	output logic [sacu_pkg::CNT_W-1:0]       store_miss_count,
	output logic [sacu_pkg::TOT_W-1:0]       total_cycle_count
);
	import sacu_pkg::*;

	// geometry derived from the parameters
	localparam int MIB    = $clog2(MAX_SETS + 1) - 1;
	localparam int SETS   = 1 << MIB;
	localparam int SI_W   = (MIB > 0) ? MIB : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NW_W   = $clog2(MAX_WAYS + 1);
	localparam int ADDR_W = (ADDRESS_BITS < ADDR_PORT_W) ? ADDRESS_BITS : ADDR_PORT_W;
	localparam int TAG_W  = ADDR_W - 2;
	localparam logic [ADDR_PORT_W-1:0] ADDR_MASK =
		{ADDR_PORT_W{1'b1}} >> (ADDR_PORT_W - ADDR_W);
	localparam logic [3:0] MIB_L = 4'(MIB);

	// sequencer codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	cfg_t                           cfg_q;
	logic                           cfg_fire;
	logic                           flush;
	logic [3:0]                     off_c;
	logic [3:0]                     ib_c;
	logic [4:0]                     nw5;
	logic [NW_W-1:0]                nw_c;

	logic [ADDR_PORT_W-1:0]         addr_m;
	logic [ADDR_PORT_W-1:0]         blk_addr;
	logic [4:0]                     tag_sh;
	logic [SI_W-1:0]                set_mask;
	logic [SI_W-1:0]                set_in;
	logic [TAG_W-1:0]               tag_in;
	logic                           in_fire;

	logic [1:0]                     state_q;
	logic [WAY_W-1:0]               way_cnt_q;
	logic                           hit_q;
	logic [WAY_W-1:0]               hit_way_q;
	logic                           is_store_q;
	logic [SI_W-1:0]                set_q;
	logic [TAG_W-1:0]               tag_q;
	logic                           way_match;
	logic                           last_way;
	logic                           out_free;
	logic                           upd_fire;

	logic                           out_valid_q;
	logic                           hit_out_q;
	logic                           alloc_q;
	logic                           wb_q;
	logic [WAY_OUT_W-1:0]           way_q;
	logic [COST_W-1:0]              cost_q;

	logic [MAX_WAYS-1:0]            rd_valid;
	logic [MAX_WAYS-1:0]            rd_dirty;
	logic [MAX_WAYS-1:0][WAY_W-1:0] rd_order;
	logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags;
	logic [MAX_WAYS-1:0]            new_valid;
	logic [MAX_WAYS-1:0]            new_dirty;
	logic [MAX_WAYS-1:0][WAY_W-1:0] new_order;
	logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags;
	outcome_t                       outcome;

	// ------------------------------------------------------------------
	// configuration registers; geometry writes empty the cache
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign flush     = cfg_fire && ((cfg_index == REG_BLK_LOG2) ||
	                   (cfg_index == REG_SET_LOG2) || (cfg_index == REG_WAYS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blk_log2    <= RST_BLK_LOG2;
			cfg_q.set_log2    <= RST_SET_LOG2;
			cfg_q.ways        <= RST_WAYS;
			cfg_q.write_alloc <= 1'b1;
			cfg_q.write_back  <= 1'b1;
			cfg_q.use_lru     <= 1'b1;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_BLK_LOG2:    cfg_q.blk_log2    <= cfg_data;
				REG_SET_LOG2:    cfg_q.set_log2    <= cfg_data;
				REG_WAYS:        cfg_q.ways        <= cfg_data;
				REG_WRITE_ALLOC: cfg_q.write_alloc <= cfg_data[0];
				REG_WRITE_BACK:  cfg_q.write_back  <= cfg_data[0];
				REG_USE_LRU:     cfg_q.use_lru     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp the geometry to what the hardware holds
	always_comb begin
		off_c = cfg_q.blk_log2;
		if (off_c < OFF_MIN) begin
			off_c = OFF_MIN;
		end else if (off_c > OFF_MAX) begin
			off_c = OFF_MAX;
		end
		ib_c = (cfg_q.set_log2 > MIB_L) ? MIB_L : cfg_q.set_log2;
		nw5  = {1'b0, cfg_q.ways};
		if (nw5 == 5'd0) begin
			nw5 = 5'd1;
		end else if (nw5 > 5'(MAX_WAYS)) begin
			nw5 = 5'(MAX_WAYS);
		end
	end

	assign nw_c = NW_W'(nw5);

	// ------------------------------------------------------------------
	// address split at acceptance
	// ------------------------------------------------------------------
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign addr_m   = address & ADDR_MASK;
	assign blk_addr = addr_m >> off_c;
	assign tag_sh   = {1'b0, off_c} + {1'b0, ib_c};
	assign tag_in   = TAG_W'(addr_m >> tag_sh);

	always_comb begin
		for (int i = 0; i < SI_W; i++) begin
			set_mask[i] = (4'(i) < ib_c);
		end
	end

	assign set_in = SI_W'(blk_addr) & set_mask;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_store_q <= req_type;
			set_q      <= set_in;
			tag_q      <= tag_in;
		end
	end

	// ------------------------------------------------------------------
	// sequencer: set read, one tag compare per cycle, row write-back
	// ------------------------------------------------------------------
	assign way_match = rd_valid[way_cnt_q] && (rd_tags[way_cnt_q] == tag_q);
	assign last_way  = ((NW_W'(way_cnt_q) + NW_W'(1)) == nw_c);
	assign out_free  = !out_valid_q || out_ready;
	assign upd_fire  = (state_q == ST_UPDATE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			way_cnt_q   <= '0;
			hit_q       <= 1'b0;
			hit_way_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result word replaces the one taken in this cycle
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q   <= ST_SEARCH;
					way_cnt_q <= '0;
					hit_q     <= 1'b0;
				end
				ST_SEARCH: begin
					// lowest matching way wins
					if (way_match) begin
						hit_q     <= 1'b1;
						hit_way_q <= way_cnt_q;
						state_q   <= ST_UPDATE;
					end else if (last_way) begin
						state_q <= ST_UPDATE;
					end else begin
						way_cnt_q <= way_cnt_q + WAY_W'(1);
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// set storage and row update
	// ------------------------------------------------------------------
	sacu_row_mem #(
		.MAX_WAYS (MAX_WAYS),
		.SETS     (SETS),
		.SI_W     (SI_W),
		.WAY_W    (WAY_W),
		.TAG_W    (TAG_W)
	) u_row_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (flush),
		.rd_en    (state_q == ST_READ),
		.rd_addr  (set_q),
		.wr_en    (upd_fire),
		.wr_addr  (set_q),
		.wr_valid (new_valid),
		.wr_dirty (new_dirty),
		.wr_order (new_order),
		.wr_tags  (new_tags),
		.rd_valid (rd_valid),
		.rd_dirty (rd_dirty),
		.rd_order (rd_order),
		.rd_tags  (rd_tags)
	);

	sacu_row_upd #(
		.MAX_WAYS (MAX_WAYS),
		.WAY_W    (WAY_W),
		.NW_W     (NW_W),
		.TAG_W    (TAG_W)
	) u_row_upd (
		.hit_in    (hit_q),
		.hit_way   (hit_way_q),
		.is_store  (is_store_q),
		.tag       (tag_q),
		.cfg       (cfg_q),
		.nw        (nw_c),
		.blk       (blk_cost(off_c)),
		.old_valid (rd_valid),
		.old_dirty (rd_dirty),
		.old_order (rd_order),
		.old_tags  (rd_tags),
		.new_valid (new_valid),
		.new_dirty (new_dirty),
		.new_order (new_order),
		.new_tags  (new_tags),
		.outcome   (outcome)
	);

	sacu_counters u_counters (
		.clk               (clk),
		.arst_n            (arst_n),
		.upd               (upd_fire),
		.is_store          (is_store_q),
		.outcome           (outcome),
		.load_count        (load_count),
		.store_count       (store_count),
		.load_hit_count    (load_hit_count),
		.load_miss_count   (load_miss_count),
		.store_hit_count   (store_hit_count),
		.store_miss_count  (store_miss_count),
		.total_cycle_count (total_cycle_count)
	);

	// ------------------------------------------------------------------
	// result word; totals come straight from the counters, which only
	// move when this register is loaded
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (upd_fire) begin
			hit_out_q <= outcome.hit;
			alloc_q   <= outcome.alloc;
			wb_q      <= outcome.wrote_back;
			way_q     <= outcome.way;
			cost_q    <= outcome.cost;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_out_q;
	assign allocated    = alloc_q;
	assign wrote_back   = wb_q;
	assign way_used     = way_q;
	assign cycles_added = cost_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_upd_result : assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("row write-back did not present a result word");

	a_accept_read : assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> ((state_q == ST_READ) && !in_ready))
		else $error("accepted word did not start a set read");

	a_search_range : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (NW_W'(way_cnt_q) < nw_c))
		else $error("tag compare beyond ways in use");

	a_totals_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!upd_fire |=> ($stable(total_cycle_count) && $stable(load_count)))
		else $error("totals moved without a row write-back");

	a_wb_alloc : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wb_q) |-> (alloc_q && !hit_out_q))
		else $error("write-back reported without a fill");

endmodule
`default_nettype wire

// ----- tb/set_assoc_cache_timing_model_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_timing_model_unit_test
// self-checking bench for the cache timing model: a short table of directed
// accesses and register writes, then randomised phases over many cache
// geometries and policies, every result word compared with a local model of
// the tag, dirty and age state and of the running counters
// ----------------------------------------------------------------------------
module set_assoc_cache_timing_model_unit_test;
	import sacu_pkg::*;

	localparam int N_SETS      = DEF_MAX_SETS;
	localparam int N_WAYS      = DEF_MAX_WAYS;
	localparam int IDX_MAX     = 8;       // largest b with 2^b <= 256 sets
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 20;      // well past the longest access latency
	localparam int PHASES      = 9;
	localparam int PHASE_WORDS = 140;
	localparam int CALM_PHASE  = 7;
	localparam int HOLD_PHASE  = 8;

	// register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam logic [CNT_W-1:0] CNT_TOP = '1;
	localparam logic [TOT_W-1:0] TOT_TOP = '1;

	// one result word as the block should present it
	typedef struct {
		outcome_t          oc;
		logic [CNT_W-1:0]  loads;
		logic [CNT_W-1:0]  stores;
		logic [CNT_W-1:0]  ld_hit;
		logic [CNT_W-1:0]  ld_miss;
		logic [CNT_W-1:0]  st_hit;
		logic [CNT_W-1:0]  st_miss;
		logic [TOT_W-1:0]  cycles;
	} cache_result_t;

	// one row of the directed table: a register write or an access
	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  st;
		logic [31:0]           addr;
		bit                    typed;
		outcome_t              oc;
	} step_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   req_type;
	logic [ADDR_PORT_W-1:0] address;
	logic                   out_valid;
	logic                   out_ready;
	logic                   hit;
	logic                   allocated;
	logic                   wrote_back;
	logic [WAY_OUT_W-1:0]   way_used;
	logic [COST_W-1:0]      cycles_added;
	logic [CNT_W-1:0]       load_count;
	logic [CNT_W-1:0]       store_count;
	logic [CNT_W-1:0]       load_hit_count;
	logic [CNT_W-1:0]       load_miss_count;
	logic [CNT_W-1:0]       store_hit_count;
	logic [CNT_W-1:0]       store_miss_count;
	logic [TOT_W-1:0]       total_cycle_count;

	// typed expectation travelling with the word on offer
	bit       offer_typed;
	outcome_t offer_oc;

	cache_result_t awaited_results[$];
	step_t         dir_steps[$];
	int            errors;
	int            cycle_count;
	bit            calm;      // no idling on either side
	bit            hold_req;  // ask the receiver for a long hold-off

	// model state: lines, age order per set, registers, counters
	bit          line_valid [N_SETS][N_WAYS];
	bit          line_dirty [N_SETS][N_WAYS];
	logic [31:0] line_tag   [N_SETS][N_WAYS];
	logic [2:0]  age_q      [N_SETS][N_WAYS];
	logic [3:0]  m_off, m_idx, m_ways;
	bit          m_alloc, m_wb, m_lru;
	logic [CNT_W-1:0] n_loads, n_stores, n_ld_hit, n_ld_miss;
	logic [CNT_W-1:0] n_st_hit, n_st_miss;
	logic [TOT_W-1:0] n_cycles;

	// settings of the random phases, extremes and out-of-range values among them
	logic [3:0] ph_off   [PHASES] = '{4'd4, 4'd2, 4'd10, 4'd15, 4'd0, 4'd5, 4'd3, 4'd6, 4'd2};
	logic [3:0] ph_idx   [PHASES] = '{4'd8, 4'd0, 4'd8, 4'd15, 4'd3, 4'd2, 4'd1, 4'd4, 4'd2};
	logic [3:0] ph_ways  [PHASES] = '{4'd4, 4'd1, 4'd8, 4'd15, 4'd0, 4'd8, 4'd3, 4'd5, 4'd2};
	bit         ph_alloc [PHASES] = '{1, 1, 0, 1, 0, 1, 0, 1, 1};
	bit         ph_wb    [PHASES] = '{1, 1, 0, 0, 1, 1, 1, 1, 0};
	bit         ph_lru   [PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1, 1};

	set_assoc_cache_timing_model_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.req_type          (req_type),
		.address           (address),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.hit               (hit),
		.allocated         (allocated),
		.wrote_back        (wrote_back),
		.way_used          (way_used),
		.cycles_added      (cycles_added),
		.load_count        (load_count),
		.store_count       (store_count),
		.load_hit_count    (load_hit_count),
		.load_miss_count   (load_miss_count),
		.store_hit_count   (store_hit_count),
		.store_miss_count  (store_miss_count),
		.total_cycle_count (total_cycle_count)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// model of the cache
	// ------------------------------------------------------------------------

	// all lines invalid and clean, every age order back to identity
	function automatic void empty_cache();
		for (int s = 0; s < N_SETS; s++) begin
			for (int w = 0; w < N_WAYS; w++) begin
				line_valid[s][w] = 1'b0;
				line_dirty[s][w] = 1'b0;
				line_tag[s][w]   = '0;
				age_q[s][w]      = 3'(w);
			end
		end
	endfunction

	// register values as used, after clamping
	function automatic void geometry(output int off, output int ib, output int nw);
		off = (m_off < OFF_MIN) ? int'(OFF_MIN) : (m_off > OFF_MAX) ? int'(OFF_MAX) : int'(m_off);
		ib  = (m_idx > IDX_MAX) ? IDX_MAX : int'(m_idx);
		nw  = (m_ways < 1) ? 1 : (m_ways > N_WAYS) ? N_WAYS : int'(m_ways);
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_BLK_LOG2: begin
				m_off = val;
				empty_cache();
			end
			REG_SET_LOG2: begin
				m_idx = val;
				empty_cache();
			end
			REG_WAYS: begin
				m_ways = val;
				empty_cache();
			end
			REG_WRITE_ALLOC: m_alloc = val[0];
			REG_WRITE_BACK:  m_wb    = val[0];
			REG_USE_LRU:     m_lru   = val[0];
			default: ;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_TOP) ? c : c + 1'b1;
	endfunction

	// one access: lookup, fill or write-through, age update, costs, totals
	function automatic cache_result_t predict_access(input logic st, input logic [31:0] a);
		int          off, ib, nw, set_i, way, p, q;
		logic [31:0] tag;
		logic [2:0]  vict;
		bit          found, touch;
		int unsigned blk, cost;
		cache_result_t r;
		geometry(off, ib, nw);
		blk   = (32'd1 << (off - 2)) * int'(MEM_COST);
		set_i = int'((a >> off) & ((32'd1 << ib) - 1));
		tag   = (a >> off) >> ib;
		found = 1'b0;
		touch = 1'b1;
		way   = 0;
		cost  = 0;
		r.oc  = '0;

		// lowest matching valid way wins
		for (int w = 0; w < nw; w++) begin
			if (!found && line_valid[set_i][w] && line_tag[set_i][w] == tag) begin
				found = 1'b1;
				way   = w;
			end
		end

		if (st) n_stores = bump(n_stores);
		else n_loads = bump(n_loads);

		if (found) begin
			cost = ACCESS_COST;
			if (st) begin
				n_st_hit = bump(n_st_hit);
				if (m_wb) line_dirty[set_i][way] = 1'b1;
				else cost += MEM_COST;
			end else begin
				n_ld_hit = bump(n_ld_hit);
			end
		end else begin
			if (st) n_st_miss = bump(n_st_miss);
			else n_ld_miss = bump(n_ld_miss);
			if (st && !m_alloc) begin
				// straight to memory, cache and ages untouched
				cost  = MEM_COST;
				touch = 1'b0;
			end else begin
				// victim from the head, rotated to the tail
				vict = age_q[set_i][0];
				for (p = 0; p + 1 < nw; p++) age_q[set_i][p] = age_q[set_i][p + 1];
				age_q[set_i][nw - 1] = vict;
				way = int'(vict);
				r.oc.alloc = 1'b1;
				if (m_wb) begin
					if (line_dirty[set_i][way]) begin
						cost += blk;
						r.oc.wrote_back = 1'b1;
					end
					line_dirty[set_i][way] = st;
				end
				cost += blk + ACCESS_COST;
				line_valid[set_i][way] = 1'b1;
				line_tag[set_i][way]   = tag;
			end
		end

		// lru: the touched way becomes youngest
		if (touch && m_lru) begin
			p = 0;
			while (p < nw && age_q[set_i][p] != 3'(way)) p++;
			if (p < nw) begin
				for (q = p; q + 1 < nw; q++) age_q[set_i][q] = age_q[set_i][q + 1];
				age_q[set_i][nw - 1] = 3'(way);
			end
		end

		n_cycles = (n_cycles > TOT_TOP - TOT_W'(cost)) ? TOT_TOP : n_cycles + TOT_W'(cost);

		r.oc.hit      = found;
		r.oc.way      = 3'(way);
		r.oc.cost     = 16'(cost);
		r.loads       = n_loads;
		r.stores      = n_stores;
		r.ld_hit      = n_ld_hit;
		r.ld_miss     = n_ld_miss;
		r.st_hit      = n_st_hit;
		r.st_miss     = n_st_miss;
		r.cycles      = n_cycles;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// helpers for the stimulus
	// ------------------------------------------------------------------------

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 38);
	endfunction

	function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		step_t s;
		s = '{default: '0};
		s.is_reg  = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	function automatic step_t plain_step(input logic st, input logic [31:0] a);
		step_t s;
		s = '{default: '0};
		s.st   = st;
		s.addr = a;
		return s;
	endfunction

	// access whose outcome is plain from the state at that point
	function automatic step_t known_step(input logic st, input logic [31:0] a, input logic h,
			input logic al, input logic wb, input logic [2:0] way, input logic [15:0] cost);
		step_t s;
		s = plain_step(st, a);
		s.typed         = 1'b1;
		s.oc.hit        = h;
		s.oc.alloc      = al;
		s.oc.wrote_back = wb;
		s.oc.way        = way;
		s.oc.cost       = cost;
		return s;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// offer one access word and hold it until taken
	task automatic offer_access(input logic st, input logic [31:0] a, input bit typed,
			input outcome_t oc);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= st;
		address     <= a;
		offer_typed <= typed;
		offer_oc    <= oc;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering, let every awaited word arrive and the row write-back finish
	task automatic settle_out();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// monitors
	// ------------------------------------------------------------------------

	// accepted access word: predict now, typed rows override the outcome part
	always @(posedge clk) begin : watch_in
		cache_result_t r;
		if (arst_n && in_valid && in_ready) begin
			r = predict_access(req_type, address);
			if (offer_typed) r.oc = offer_oc;
			awaited_results.push_back(r);
		end
		if (arst_n && cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
	end

	// accepted result word against the oldest expectation
	always @(posedge clk) begin : watch_out
		cache_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result word with nothing awaited", $time);
				errors++;
			end else begin
				e = awaited_results.pop_front();
				check_field("hit", e.oc.hit, hit);
				check_field("allocated", e.oc.alloc, allocated);
				check_field("wrote_back", e.oc.wrote_back, wrote_back);
				check_field("way_used", e.oc.way, way_used);
				check_field("cycles_added", e.oc.cost, cycles_added);
				check_field("load_count", e.loads, load_count);
				check_field("store_count", e.stores, store_count);
				check_field("load_hit_count", e.ld_hit, load_hit_count);
				check_field("load_miss_count", e.ld_miss, load_miss_count);
				check_field("store_hit_count", e.st_hit, store_hit_count);
				check_field("store_miss_count", e.st_miss, store_miss_count);
				check_field("total_cycle_count", e.cycles, total_cycle_count);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin : out_side
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= !take_break();
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender and sequence of the run
	// ------------------------------------------------------------------------
	initial begin : run
		int          ph, k, off, ib, nw, hi;
		logic [31:0] a, tg, tag_base;
		step_t       s;

		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		req_type    = 1'b0;
		address     = '0;
		offer_typed = 1'b0;
		offer_oc    = '0;
		errors      = 0;
		cycle_count = 0;
		calm        = 1'b0;
		hold_req    = 1'b0;

		// model comes up as the block does after reset
		empty_cache();
		m_off   = RST_BLK_LOG2;
		m_idx   = RST_SET_LOG2;
		m_ways  = RST_WAYS;
		m_alloc = 1'b1;
		m_wb    = 1'b1;
		m_lru   = 1'b1;
		n_loads = '0; n_stores = '0; n_ld_hit = '0; n_ld_miss = '0;
		n_st_hit = '0; n_st_miss = '0; n_cycles = '0;

		// directed table, reset geometry: 16-byte blocks, 256 sets, 4 ways
		// blocks at 0x0, 0x1000, 0x2000, 0x3000, 0x4000 all land in set 0
		dir_steps.push_back(known_step(1'b0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 3'd0, 16'd401));
		dir_steps.push_back(known_step(1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 3'd0, 16'd1));
		dir_steps.push_back(known_step(1'b1, 32'h0000_0004, 1'b1, 1'b0, 1'b0, 3'd0, 16'd1));
		dir_steps.push_back(known_step(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 3'd0, 16'd401));
		dir_steps.push_back(known_step(1'b1, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 3'd0, 16'd1));
		dir_steps.push_back(known_step(1'b0, 32'h0000_1000, 1'b0, 1'b1, 1'b0, 3'd1, 16'd401));
		dir_steps.push_back(known_step(1'b0, 32'h0000_2008, 1'b0, 1'b1, 1'b0, 3'd2, 16'd401));
		dir_steps.push_back(known_step(1'b0, 32'h0000_300C, 1'b0, 1'b1, 1'b0, 3'd3, 16'd401));
		// set full, dirty way 0 is the oldest: write-back plus fill
		dir_steps.push_back(known_step(1'b0, 32'h0000_4000, 1'b0, 1'b1, 1'b1, 3'd0, 16'd801));
		dir_steps.push_back(plain_step(1'b0, 32'h0000_0000));
		// store miss without allocation goes straight to memory
		dir_steps.push_back(reg_step(REG_WRITE_ALLOC, 4'd0));
		dir_steps.push_back(known_step(1'b1, 32'h0000_5000, 1'b0, 1'b0, 1'b0, 3'd0, 16'd100));
		// write-through store hit
		dir_steps.push_back(reg_step(REG_WRITE_BACK, 4'd0));
		dir_steps.push_back(known_step(1'b1, 32'h0000_2000, 1'b1, 1'b0, 1'b0, 3'd2, 16'd101));
		// undecoded index: ignored, the cache keeps its contents
		dir_steps.push_back(reg_step(REG_SPARE_A, 4'd15));
		dir_steps.push_back(known_step(1'b0, 32'h0000_2000, 1'b1, 1'b0, 1'b0, 3'd2, 16'd1));
		dir_steps.push_back(plain_step(1'b1, 32'h0000_6000));
		dir_steps.push_back(reg_step(REG_WRITE_ALLOC, 4'd1));
		dir_steps.push_back(plain_step(1'b1, 32'h0000_7000));
		// offset clamped to 10 and to 2, each write empties the cache
		dir_steps.push_back(reg_step(REG_BLK_LOG2, 4'd15));
		dir_steps.push_back(known_step(1'b0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 3'd0, 16'd25601));
		dir_steps.push_back(reg_step(REG_BLK_LOG2, 4'd0));
		dir_steps.push_back(known_step(1'b0, 32'h0000_0003, 1'b0, 1'b1, 1'b0, 3'd0, 16'd101));
		// one way, one set, largest block, write-back: worst-case cost
		dir_steps.push_back(reg_step(REG_WAYS, 4'd0));
		dir_steps.push_back(reg_step(REG_SET_LOG2, 4'd15));
		dir_steps.push_back(reg_step(REG_WRITE_BACK, 4'd1));
		dir_steps.push_back(reg_step(REG_BLK_LOG2, 4'd10));
		dir_steps.push_back(reg_step(REG_SET_LOG2, 4'd0));
		dir_steps.push_back(known_step(1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 3'd0, 16'd25601));
		dir_steps.push_back(known_step(1'b1, 32'h0000_0400, 1'b0, 1'b1, 1'b1, 3'd0, 16'd51201));
		// fifo with the way count clamped to 8
		dir_steps.push_back(reg_step(REG_USE_LRU, 4'd0));
		dir_steps.push_back(reg_step(REG_WAYS, 4'd15));
		dir_steps.push_back(plain_step(1'b0, 32'h8000_0000));
		dir_steps.push_back(plain_step(1'b0, 32'h8000_0400));
		dir_steps.push_back(plain_step(1'b0, 32'h8000_0000));
		dir_steps.push_back(plain_step(1'b1, 32'h7FFF_FFFF));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_steps[i]) begin
			s = dir_steps[i];
			if (s.is_reg) begin
				settle_out();
				write_reg(s.reg_idx, s.reg_val);
			end else begin
				offer_access(s.st, s.addr, s.typed, s.oc);
			end
		end

		// random phases, each with its own geometry and policy
		for (ph = 0; ph < PHASES; ph++) begin
			settle_out();
			write_reg(REG_BLK_LOG2, ph_off[ph]);
			write_reg(REG_SET_LOG2, ph_idx[ph]);
			write_reg(REG_WAYS, ph_ways[ph]);
			// single-bit registers get junk in the upper data bits
			write_reg(REG_WRITE_ALLOC, {3'($urandom_range(7)), ph_alloc[ph]});
			write_reg(REG_WRITE_BACK, {3'($urandom_range(7)), ph_wb[ph]});
			write_reg(REG_USE_LRU, {3'($urandom_range(7)), ph_lru[ph]});
			write_reg(REG_SPARE_B, 4'($urandom_range(15)));
			calm = (ph == CALM_PHASE);
			geometry(off, ib, nw);
			hi = (1 << ib) - 1;
			if (hi > 3) hi = 3;
			tag_base = $urandom;
			for (k = 0; k < PHASE_WORDS; k++) begin
				if (ph == HOLD_PHASE && k == 30) hold_req = 1'b1;
				if ($urandom_range(99) < 80) begin
					// a few tags over a few sets, so that sets fill and evict
					tg = tag_base + 32'($urandom_range(nw + 1));
					a  = (tg << (off + ib)) | (32'($urandom_range(hi)) << off)
						| ($urandom & ((32'd1 << off) - 1));
				end else begin
					a = $urandom;
				end
				offer_access(1'($urandom_range(1)), a, 1'b0, '0);
			end
			calm = 1'b0;
		end

		settle_out();
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
